### rtl/core/bes_pkg.sv
// shared types and constants for the button and encoder event scanner
package bes_pkg;

  localparam int unsigned PinW        = 7;
  localparam int unsigned PinIdxW     = $clog2(PinW);
  localparam int unsigned LockoutW    = 16;
  localparam int unsigned ButtonCount = 5;
  localparam int unsigned EncABit     = 4;
  localparam int unsigned EncBBit     = 5;
  localparam int unsigned EncBtnBit   = 6;

  localparam logic [LockoutW-1:0] LockoutReset = 16'd50;
  localparam logic [PinW-1:0]     PinsIdle     = 7'h7f;
  localparam logic [PinW-1:0]     TurnRight    = 7'h10;
  localparam logic [PinW-1:0]     TurnLeft     = 7'h20;

  // per-button controls for one step of the pipeline
  typedef struct packed {
    logic step;
    logic tick;
    logic fall;
  } lane_ctrl_t;

  // pin bit that a button lane watches: four plain buttons, then the encoder button
  function automatic logic [PinIdxW-1:0] lane_pin(input int unsigned lane);
    logic [PinIdxW-1:0] pin;
    pin = (lane < 4) ? PinIdxW'(lane) : PinIdxW'(EncBtnBit);
    return pin;
  endfunction

endpackage

### rtl/core/bes_lane.sv
// one button lane: saturating elapsed-time counter and lockout check
module bes_lane
  import bes_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  lane_ctrl_t          ctrl_i,
  input  logic [LockoutW-1:0] lockout_i,
  output logic                press_o
);

  localparam int unsigned CmpW = (TIMER_BITS > LockoutW) ? TIMER_BITS : LockoutW;

  logic [TIMER_BITS-1:0] cnt_q, cnt_d, cnt_inc;
  logic [CmpW-1:0]       cnt_ext, lock_ext;

  always_comb begin
    cnt_inc = cnt_q;
    if (ctrl_i.tick && (cnt_q != {TIMER_BITS{1'b1}})) begin
      cnt_inc = cnt_q + TIMER_BITS'(1);
    end
  end

  assign cnt_ext  = CmpW'(cnt_inc);
  assign lock_ext = CmpW'(lockout_i);
  assign press_o  = ctrl_i.fall && (cnt_ext > lock_ext);

  always_comb begin
    cnt_d = cnt_q;
    if (ctrl_i.step) begin
      cnt_d = press_o ? '0 : cnt_inc;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

endmodule

### rtl/core/button_and_encoder_event_scanner_unit.sv
// Top level of the button and encoder event scanner.
// Data path: an accepted sample is held in the input register, and its event word
// is registered in the output register when the sample steps out of the pipe.
// Throughput: one sample per clock cycle; it stalls only while an event word
// waits in the output register and the next sample also makes an event.
// Reset: counters cleared, previous pins all high, lockout 50 ms, pipeline empty.
module button_and_encoder_event_scanner_unit
  import bes_pkg::*;
#(
  parameter int unsigned TIMER_BITS = 16
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                s_axis_tvalid,
  output logic                s_axis_tready,
  input  logic [7:0]          s_axis_tdata,  // [6:0] pins, [7] zero
  input  logic                s_axis_tuser,  // [0] ms_tick
  output logic                m_axis_tvalid,
  input  logic                m_axis_tready,
  output logic [7:0]          m_axis_tdata,  // [6:0] event_bits, [7] zero
  input  logic                cfg_we_i,
  input  logic [LockoutW-1:0] cfg_wdata_i
);

  logic                in_valid_q;
  logic [PinW-1:0]     in_pins_q;
  logic                in_tick_q;
  logic [PinW-1:0]     prev_q;
  logic [LockoutW-1:0] lockout_q;
  logic                out_valid_q;
  logic [PinW-1:0]     out_bits_q;

  logic [PinW-1:0]        falling;
  logic [ButtonCount-1:0] press;
  logic [PinW-1:0]        events;
  logic                   has_event;
  logic                   out_free;
  logic                   step;

  assign falling   = prev_q & ~in_pins_q;
  assign has_event = (events != '0);
  assign out_free  = !out_valid_q || m_axis_tready;
  // a sample with no event leaves the pipe without needing the output slot
  assign step      = in_valid_q && (out_free || !has_event);

  assign s_axis_tready = !in_valid_q || step;

  for (genvar k = 0; k < ButtonCount; k++) begin : g_lane
    lane_ctrl_t ctrl;
    assign ctrl = '{step: step, tick: in_tick_q, fall: falling[lane_pin(k)]};

    bes_lane #(
      .TIMER_BITS(TIMER_BITS)
    ) u_lane (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (ctrl),
      .lockout_i(lockout_q),
      .press_o  (press[k])
    );
  end

  always_comb begin
    events = '0;
    for (int unsigned k = 0; k < ButtonCount; k++) begin
      events[lane_pin(k)] = press[k];
    end
    if (falling[EncABit]) begin
      events = events | (in_pins_q[EncBBit] ? TurnLeft : TurnRight);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      prev_q      <= PinsIdle;
      lockout_q   <= LockoutReset;
      out_valid_q <= 1'b0;
    end else begin
      if (cfg_we_i) begin
        lockout_q <= cfg_wdata_i;
      end
      if (s_axis_tready) begin
        in_valid_q <= s_axis_tvalid;
      end
      if (step) begin
        prev_q <= in_pins_q;
      end
      if (step && has_event) begin
        out_valid_q <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_pins_q <= s_axis_tdata[PinW-1:0];
      in_tick_q <= s_axis_tuser;
    end
    if (step && has_event) begin
      out_bits_q <= events;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {1'b0, out_bits_q};

  a_word_nonzero : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[PinW-1:0] != '0))
    else $error("event word is zero");

  a_one_turn : assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[EncABit] && m_axis_tdata[EncBBit]))
    else $error("both turn directions in one word");

  a_no_overwrite : assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !m_axis_tready) |-> !(step && has_event))
    else $error("pending event word overwritten");

  a_prev_follows : assert property (@(posedge clk_i) disable iff (!rst_ni)
    step |=> (prev_q == $past(in_pins_q)))
    else $error("previous pins not updated on step");

endmodule

### dv/button_and_encoder_event_scanner_unit_test.sv
`timescale 1ns / 1ps
// self-checking stream testbench for the button and encoder event scanner unit
module button_and_encoder_event_scanner_unit_test
  import bes_pkg::*;
;

  localparam int unsigned TimerBits   = 16;
  localparam int unsigned StallLimit  = 5000;
  localparam int unsigned HoldAfter   = 60;
  localparam int unsigned HoldCycles  = 400;
  localparam int unsigned DrainCycles = 6;
  localparam int unsigned MaxReports  = 10;
  localparam int unsigned TickSamples = 16;

  // encoder {B, A} levels in quadrature order
  localparam logic [1:0] QuadBA [4] = '{2'b11, 2'b10, 2'b00, 2'b01};

  typedef enum logic [1:0] {IdleRecvHeavy, IdleSendHeavy, IdleOff} idle_mode_e;

  typedef struct packed {
    logic [PinW-1:0] pins;
    logic            tick;
  } sample_t;

  logic                clk_i         = 1'b0;
  logic                rst_ni        = 1'b0;
  logic                s_axis_tvalid = 1'b0;
  logic                s_axis_tready;
  logic [7:0]          s_axis_tdata  = {1'b0, PinsIdle};  // [6:0] pins, [7] zero
  logic                s_axis_tuser  = 1'b0;              // [0] ms_tick
  logic                m_axis_tvalid;
  logic                m_axis_tready = 1'b0;
  logic [7:0]          m_axis_tdata;                      // [6:0] event_bits, [7] zero
  logic                cfg_we_i      = 1'b0;
  logic [LockoutW-1:0] cfg_wdata_i   = '0;

  idle_mode_e idle_mode = IdleRecvHeavy;

  sample_t         pending_samples [$];
  logic [PinW-1:0] expected_events [$];
  int unsigned     samples_queued = 0;
  int unsigned     samples_taken  = 0;
  int unsigned     mismatches     = 0;
  int unsigned     stall_cycles   = 0;

  // scanner state as seen by the predictor
  logic [LockoutW-1:0]  lockout_now = LockoutReset;
  logic [PinW-1:0]      last_pins   = PinsIdle;
  logic [TimerBits-1:0] ms_since_press [ButtonCount] = '{default: '0};

  // stimulus generator state
  logic [PinW-1:0] gen_pins = PinsIdle;
  logic [1:0]      gen_quad = 2'd0;

  button_and_encoder_event_scanner_unit #(
    .TIMER_BITS(TimerBits)
  ) i_dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i)
  );

  initial begin
    forever #1 clk_i = ~clk_i;
  end

  // advance the button timers, judge edges and return the event word
  function automatic logic [PinW-1:0] scan_sample(input logic [PinW-1:0] pins,
                                                  input logic tick);
    logic [PinW-1:0]      falling;
    logic [PinW-1:0]      events;
    logic [TimerBits-1:0] age;
    logic [PinIdxW-1:0]   pin;
    falling = last_pins & ~pins;
    events  = '0;
    for (int unsigned b = 0; b < ButtonCount; b++) begin
      pin = (b < 4) ? PinIdxW'(b) : PinIdxW'(EncBtnBit);
      age = ms_since_press[b];
      if (tick && age != '1) age = age + 1'b1;
      if (falling[pin] && age > lockout_now) begin
        events[pin] = 1'b1;
        age = '0;
      end
      ms_since_press[b] = age;
    end
    if (falling[EncABit]) events = events | (pins[EncBBit] ? TurnLeft : TurnRight);
    last_pins = pins;
    return events;
  endfunction

  task automatic queue_sample(input logic [PinW-1:0] pins, input logic tick);
    sample_t s;
    s.pins = pins;
    s.tick = tick;
    pending_samples.push_back(s);
    samples_queued++;
  endtask

  // mostly clean presses, releases and quadrature steps, with some raw noise
  task automatic queue_random(input int unsigned count, input int unsigned tick_pct);
    for (int unsigned n = 0; n < count; n++) begin
      if ($urandom_range(99) < 8) begin
        gen_pins = PinW'($urandom);
      end else begin
        for (int unsigned k = 0; k < 4; k++)
          if ($urandom_range(99) < 12) gen_pins[k] = ~gen_pins[k];
        if ($urandom_range(99) < 12) gen_pins[EncBtnBit] = ~gen_pins[EncBtnBit];
        if ($urandom_range(99) < 30) begin
          if ($urandom_range(1) == 0) gen_quad = gen_quad + 2'd1;
          else gen_quad = gen_quad - 2'd1;
        end
        gen_pins[EncBBit] = QuadBA[gen_quad][1];
        gen_pins[EncABit] = QuadBA[gen_quad][0];
      end
      queue_sample(gen_pins, $urandom_range(99) < tick_pct);
    end
  endtask

  // every queued sample taken, every event word back, pipeline flushed
  task automatic wait_drained();
    while (samples_taken != samples_queued || expected_events.size() != 0)
      @(posedge clk_i);
    repeat (DrainCycles) @(posedge clk_i);
  endtask

  task automatic write_lockout(input logic [LockoutW-1:0] value);
    @(posedge clk_i);
    cfg_we_i    <= 1'b1;
    cfg_wdata_i <= value;
    lockout_now = value;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic set_idling(input idle_mode_e mode);
    @(posedge clk_i);
    idle_mode <= mode;
  endtask

  // sample driver
  always @(posedge clk_i) begin : drive_samples
    logic [PinW-1:0] word;
    sample_t         next_sample;
    int unsigned     idle_pct;
    case (idle_mode)
      IdleRecvHeavy: idle_pct = 37;
      IdleSendHeavy: idle_pct = 46;
      default:       idle_pct = 0;
    endcase
    if (!rst_ni) begin
      s_axis_tvalid <= 1'b0;
    end else begin
      if (s_axis_tvalid && s_axis_tready) begin
        word = scan_sample(s_axis_tdata[PinW-1:0], s_axis_tuser);
        if (word != '0) expected_events.push_back(word);
        samples_taken++;
      end
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_samples.size() != 0 && $urandom_range(99) >= idle_pct) begin
          next_sample = pending_samples.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata  <= {1'b0, next_sample.pins};
          s_axis_tuser  <= next_sample.tick;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // event word receiver, with one long hold-off to back the block up
  always @(posedge clk_i) begin : drive_ready
    int unsigned words_taken;
    int unsigned hold_left;
    bit          hold_done;
    int unsigned idle_pct;
    case (idle_mode)
      IdleRecvHeavy: idle_pct = 46;
      IdleSendHeavy: idle_pct = 37;
      default:       idle_pct = 0;
    endcase
    if (!rst_ni) begin
      m_axis_tready <= 1'b0;
      words_taken = 0;
      hold_left   = 0;
      hold_done   = 1'b0;
    end else begin
      if (m_axis_tvalid && m_axis_tready) words_taken++;
      if (hold_left != 0) begin
        hold_left--;
        m_axis_tready <= 1'b0;
      end else if (!hold_done && words_taken >= HoldAfter) begin
        hold_done = 1'b1;
        hold_left = HoldCycles;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= idle_pct);
      end
    end
  end

  // event word checker
  always @(posedge clk_i) begin : check_events
    logic [PinW-1:0] want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_events.size() == 0) begin
        mismatches++;
        if (mismatches <= MaxReports)
          $display("event word %02h with none expected", m_axis_tdata);
      end else begin
        want = expected_events.pop_front();
        if (m_axis_tdata[PinW-1:0] !== want) begin
          mismatches++;
          if (mismatches <= MaxReports)
            $display("event_bits mismatch: expected %02h, got %02h", want,
                     m_axis_tdata[PinW-1:0]);
        end
      end
    end
  end

  // watchdog on cycles without any word moving
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= StallLimit) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin : run
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;

    // presses right after reset are locked out, turns are not
    queue_sample(PinsIdle, 1'b0);
    queue_sample(7'h00, 1'b1);
    queue_sample(PinsIdle, 1'b1);
    queue_sample(7'h6f, 1'b0);
    queue_sample(PinsIdle, 1'b0);
    wait_drained();

    // zero lockout: tick in the same sample as the press still counts
    write_lockout('0);
    queue_sample(7'h7e, 1'b0);
    queue_sample(PinsIdle, 1'b0);
    queue_sample(7'h7e, 1'b0);
    queue_sample(PinsIdle, 1'b0);
    queue_sample(7'h7e, 1'b1);
    queue_sample(PinsIdle, 1'b0);
    queue_sample(7'h31, 1'b0);
    queue_sample(PinsIdle, 1'b0);
    queue_sample(7'h00, 1'b1);
    queue_sample(PinsIdle, 1'b1);
    queue_sample(7'h2f, 1'b0);
    queue_sample(7'h0f, 1'b1);
    queue_sample(PinsIdle, 1'b0);
    wait_drained();

    queue_random(180, 40);
    wait_drained();
    write_lockout(16'd3);
    queue_random(180, 60);
    wait_drained();

    set_idling(IdleSendHeavy);
    write_lockout(16'd1);
    queue_random(180, 50);
    wait_drained();
    write_lockout(LockoutReset);
    queue_random(180, 95);
    wait_drained();

    set_idling(IdleOff);
    write_lockout(LockoutW'($urandom_range(20)));
    queue_random(180, 60);
    wait_drained();
    write_lockout(16'd8);
    queue_random(180, 70);
    wait_drained();

    // a lockout at the top of its range blocks every press
    write_lockout('1);
    for (int unsigned n = 0; n < TickSamples; n++) queue_sample(PinsIdle, 1'b1);
    queue_sample(7'h00, 1'b0);
    wait_drained();
    // one below the top still blocks timers that have not run that long
    write_lockout('1 - 1'b1);
    queue_sample(PinsIdle, 1'b0);
    queue_sample(7'h00, 1'b0);
    queue_sample(PinsIdle, 1'b1);
    queue_sample(7'h00, 1'b1);
    wait_drained();

    if (mismatches == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
